[design/fpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // port widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int ACT_W  = 4;

  // default number format, Q24.8 in a 32-bit word
  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  // operation codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_t;

endpackage

[design/fixed_point_alu_q24_8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Pipelined signed fixed-point ALU: add, sub, mul, div, compares, min/max,
// inc/dec and integer conversions, with a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | beat contents
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, operand_a, operand_b
//  out     | out_valid / out_ready| result_value, compare_true, status
//
//  one beat enters per cycle unless the pipe is held; every action takes the
//  same path, so results leave in order; the depth is set by the restoring
//  divider, one quotient bit per stage
//  a two-entry output buffer lets the pipe keep moving while a result waits;
//  the whole pipe holds only when that buffer is full and out_ready is low
//  rst (synchronous) clears the stage valid bits and the buffer count
//
module fixed_point_alu_q24_8
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     compare_true,
  output logic                     status
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = W + F;      // widened dividend width
  localparam int NS = DW + 2;     // input stage, setup stage, DW divide steps

  typedef struct packed {
    logic          valid;
    action_t       act;
    logic [W-1:0]  opa;
    logic [W-1:0]  opb;
    logic [W-1:0]  res;
    logic          cmp;
    logic          dz;
    logic          neg;
    logic [W-1:0]  dvs;
    logic [W-1:0]  rem;
    logic [DW-1:0] dq;
  } stage_t;

  typedef struct packed {
    logic [W-1:0] res;
    logic         cmp;
    logic         st;
  } result_t;

  stage_t  pipe      [NS];
  stage_t  pipe_next [NS];
  logic    en;

  // output buffer
  result_t ob_head;
  result_t ob_tail;
  logic [1:0] cnt;
  result_t fin;
  logic    push;
  logic    pop;

  // ---------------- stage 0: simple operations ----------------
  logic signed [W-1:0] in_a;
  logic signed [W-1:0] in_b;
  logic                in_lt;
  logic                in_gt;
  logic                in_eq;

  always_comb begin
    in_a  = operand_a[W-1:0];
    in_b  = operand_b[W-1:0];
    in_lt = in_a < in_b;
    in_gt = in_a > in_b;
    in_eq = in_a == in_b;
    pipe_next[0]       = '0;
    pipe_next[0].valid = in_valid;
    pipe_next[0].act   = action_t'(action);
    pipe_next[0].opa   = in_a;
    pipe_next[0].opb   = in_b;
    unique case (action_t'(action))
      ACT_ADD:      pipe_next[0].res = in_a + in_b;
      ACT_SUB:      pipe_next[0].res = in_a - in_b;
      ACT_MUL:      pipe_next[0].res = '0;
      ACT_DIV:      pipe_next[0].res = '0;
      ACT_GT:       pipe_next[0].cmp = in_gt;
      ACT_LT:       pipe_next[0].cmp = in_lt;
      ACT_GE:       pipe_next[0].cmp = ~in_lt;
      ACT_LE:       pipe_next[0].cmp = ~in_gt;
      ACT_EQ:       pipe_next[0].cmp = in_eq;
      ACT_NE:       pipe_next[0].cmp = ~in_eq;
      ACT_MIN:      pipe_next[0].res = in_lt ? in_a : in_b;
      ACT_MAX:      pipe_next[0].res = in_gt ? in_a : in_b;
      ACT_INC:      pipe_next[0].res = in_a + W'(1);
      ACT_DEC:      pipe_next[0].res = in_a - W'(1);
      ACT_FROM_INT: pipe_next[0].res = in_a << F;
      ACT_TO_INT:   pipe_next[0].res = in_a >>> F;
    endcase
  end

  // ---------------- stage 1: multiply and divider setup ----------------
  logic signed [W-1:0]   s1_a;
  logic signed [W-1:0]   s1_b;
  logic signed [2*W-1:0] s1_prod;
  logic signed [2*W-1:0] s1_prod_sh;
  logic [W-1:0]          s1_abs_a;
  logic [W-1:0]          s1_abs_b;

  always_comb begin
    s1_a       = pipe[0].opa;
    s1_b       = pipe[0].opb;
    s1_prod    = s1_a * s1_b;
    s1_prod_sh = s1_prod >>> F;
    s1_abs_a   = s1_a[W-1] ? (~pipe[0].opa + W'(1)) : pipe[0].opa;
    s1_abs_b   = s1_b[W-1] ? (~pipe[0].opb + W'(1)) : pipe[0].opb;
    pipe_next[1]     = pipe[0];
    pipe_next[1].res = (pipe[0].act == ACT_MUL) ? s1_prod_sh[W-1:0] : pipe[0].res;
    pipe_next[1].dz  = (pipe[0].opb == '0);
    pipe_next[1].neg = s1_a[W-1] ^ s1_b[W-1];
    pipe_next[1].dvs = s1_abs_b;
    pipe_next[1].rem = '0;
    pipe_next[1].dq  = {s1_abs_a, {F{1'b0}}};
  end

  // ---------------- divide steps: one quotient bit per stage ----------------
  for (genvar k = 2; k < NS; k++) begin : g_div_step
    logic [W:0] trial;
    logic [W:0] diff;

    always_comb begin
      trial        = {pipe[k-1].rem, pipe[k-1].dq[DW-1]};
      diff         = trial - {1'b0, pipe[k-1].dvs};
      pipe_next[k] = pipe[k-1];
      if (!diff[W]) begin
        pipe_next[k].rem = diff[W-1:0];
        pipe_next[k].dq  = {pipe[k-1].dq[DW-2:0], 1'b1};
      end else begin
        pipe_next[k].rem = trial[W-1:0];
        pipe_next[k].dq  = {pipe[k-1].dq[DW-2:0], 1'b0};
      end
    end
  end

  // ---------------- final select into the output buffer ----------------
  logic [W-1:0] quo;
  logic [W-1:0] div_res;

  always_comb begin
    quo     = pipe[NS-1].dq[W-1:0];
    div_res = pipe[NS-1].dz ? '0 : (pipe[NS-1].neg ? (~quo + W'(1)) : quo);
    fin.res = (pipe[NS-1].act == ACT_DIV) ? div_res : pipe[NS-1].res;
    fin.cmp = pipe[NS-1].cmp;
    fin.st  = (pipe[NS-1].act == ACT_DIV) && pipe[NS-1].dz;
  end

  // pipe advance: hold only when the buffer is full, not draining, and a
  // beat is waiting at the end of the pipe
  assign en       = (cnt != 2'd2) || out_ready || !pipe[NS-1].valid;
  assign in_ready = en;
  assign push     = en && pipe[NS-1].valid;
  assign pop      = out_valid && out_ready;

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) pipe[k].valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NS; k++) pipe[k] <= pipe_next[k];
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) ob_head <= fin;
          else ob_tail <= fin;
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          ob_head <= ob_tail;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            ob_head <= fin;
          end else begin
            ob_head <= ob_tail;
            ob_tail <= fin;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // output beat
  assign out_valid    = (cnt != 2'd0);
  assign result_value = DATA_W'($signed(ob_head.res));
  assign compare_true = ob_head.cmp;
  assign status       = ob_head.st;

endmodule
